>>> rtl/rrts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_pkg: shared types and constants of the round-robin thread scheduler
// Holds the request and result words, the operation, error and slot state
// codes, and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package rrts_pkg;

  localparam int unsigned THREAD_SLOTS_DEF = 16;
  localparam int unsigned PRIO_BITS_DEF    = 8;

  // Priority of the initial thread in slot zero after reset.
  localparam logic [7:0] MAIN_PRIO_RESET = 8'd31;

  // Block kinds; every other code means blocked.
  localparam logic [1:0] KIND_WAITING = 2'd1;
  localparam logic [1:0] KIND_HANGING = 2'd2;

  typedef enum logic [1:0] {
    OP_CREATE  = 2'd0,
    OP_EXPIRE  = 2'd1,
    OP_BLOCK   = 2'd2,
    OP_UNBLOCK = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ERR_OK          = 2'd0,
    ERR_NO_READY    = 2'd1,
    ERR_BUSY_FULL   = 2'd2,
    ERR_BAD_UNBLOCK = 2'd3
  } err_e;

  typedef enum logic [2:0] {
    ST_UNUSED  = 3'd0,
    ST_RUNNING = 3'd1,
    ST_READY   = 3'd2,
    ST_BLOCKED = 3'd3,
    ST_WAITING = 3'd4,
    ST_HANGING = 3'd5
  } slot_state_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_APPLY,
    S_DISPATCH,
    S_POP,
    S_PRIO,
    S_EMIT
  } ctrl_state_e;

  typedef struct packed {
    op_e        op;
    logic [3:0] thread_id;
    logic [7:0] priority_req;
    logic [1:0] block_kind;
  } req_t;

  typedef struct packed {
    logic [3:0] running_id;
    logic       switched;
    logic [7:0] time_slice;
    err_e       error_code;
  } res_t;

  typedef struct packed {
    logic load;
    logic wr_create;
    logic wr_requeue;
    logic wr_front;
    logic wr_block;
    logic pop;
    logic go_idle;
    logic err_set;
    err_e err_val;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    op_e  op;
    logic cpu_idle;
    logic ring_full;
    logic ring_empty;
    logic create_ok;
    logic unblock_bad;
    logic unblock_ready;
  } dp_status_t;

endpackage

>>> rtl/rrts_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_ctrl: sequencing controller
// Steps one request through lookup, update, dispatch and result phases.
// ----------------------------------------------------------------------------
module rrts_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  rrts_pkg::dp_status_t sts_i,
  output rrts_pkg::ctrl_cmd_t cmd_o
);
  import rrts_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.err_val = ERR_OK;
    busy    = 1'b1;
    case (state_q)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_FETCH;
        end
      end
      // Slot state read of the request's thread is issued here and lands in S_APPLY.
      S_FETCH: begin
        state_d = S_APPLY;
      end
      S_APPLY: begin
        case (sts_i.op)
          OP_CREATE: begin
            if (sts_i.create_ok) begin
              cmd_o.wr_create = 1'b1;
            end else begin
              cmd_o.err_set = 1'b1;
              cmd_o.err_val = ERR_BUSY_FULL;
            end
            state_d = S_PRIO;
          end
          OP_EXPIRE: begin
            if (sts_i.cpu_idle) begin
              state_d = S_DISPATCH;
            end else if (sts_i.ring_full) begin
              cmd_o.err_set = 1'b1;
              cmd_o.err_val = ERR_BUSY_FULL;
              state_d       = S_PRIO;
            end else begin
              cmd_o.wr_requeue = 1'b1;
              state_d          = S_DISPATCH;
            end
          end
          OP_BLOCK: begin
            cmd_o.wr_block = !sts_i.cpu_idle;
            state_d        = S_DISPATCH;
          end
          default: begin
            if (sts_i.unblock_bad) begin
              cmd_o.err_set = 1'b1;
              cmd_o.err_val = ERR_BAD_UNBLOCK;
            end else if (!sts_i.unblock_ready) begin
              if (sts_i.ring_full) begin
                cmd_o.err_set = 1'b1;
                cmd_o.err_val = ERR_BUSY_FULL;
              end else begin
                cmd_o.wr_front = 1'b1;
              end
            end
            state_d = S_PRIO;
          end
        endcase
      end
      // The ring head read is issued here and lands in S_POP.
      S_DISPATCH: begin
        if (sts_i.ring_empty) begin
          cmd_o.go_idle = 1'b1;
          cmd_o.err_set = 1'b1;
          cmd_o.err_val = ERR_NO_READY;
          state_d       = S_PRIO;
        end else begin
          state_d = S_POP;
        end
      end
      S_POP: begin
        cmd_o.pop = 1'b1;
        state_d   = S_PRIO;
      end
      // Priority read of the running thread lands in S_EMIT.
      S_PRIO: begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        cmd_o.emit = 1'b1;
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/rrts_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_datapath: slot tables, ready ring and result register
// Holds slot states and priorities, the ready deque and the running thread.
// ----------------------------------------------------------------------------
module rrts_datapath #(
  parameter int unsigned THREAD_SLOTS = rrts_pkg::THREAD_SLOTS_DEF,
  parameter int unsigned PRIO_BITS    = rrts_pkg::PRIO_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rrts_pkg::req_t       req_i,
  input  rrts_pkg::ctrl_cmd_t  cmd_i,
  output rrts_pkg::dp_status_t sts_o,
  input  logic                 cfg_valid_i,
  input  logic [7:0]           cfg_data_i,
  output rrts_pkg::res_t       res_o,
  output logic                 res_valid_o
);
  import rrts_pkg::*;

  localparam int unsigned ID_W  = $clog2(THREAD_SLOTS);
  localparam int unsigned CNT_W = $clog2(THREAD_SLOTS + 1);
  localparam int unsigned SUM_W = ID_W + 1;
  localparam logic [ID_W-1:0]  LAST_SLOT = ID_W'(THREAD_SLOTS - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(THREAD_SLOTS);
  localparam logic [SUM_W-1:0] SLOTS_SUM = SUM_W'(THREAD_SLOTS);

  req_t                 req_q;
  logic                 started_q;
  logic [PRIO_BITS-1:0] slot0_prio_q;
  logic [ID_W-1:0]      head_q;
  logic [CNT_W-1:0]     count_q;
  logic [ID_W-1:0]      cur_q;
  logic                 idle_q;
  err_e                 err_q;
  logic                 switched_q;
  res_t                 res_q;
  logic                 res_valid_q;

  slot_state_e          stat_mem [THREAD_SLOTS];
  logic [PRIO_BITS-1:0] prio_mem [THREAD_SLOTS];
  logic [ID_W-1:0]      ring_mem [THREAD_SLOTS];
  logic                 stat_vld_q [THREAD_SLOTS];
  logic                 prio_vld_q [THREAD_SLOTS];

  slot_state_e          stat_rd_q;
  logic                 stat_rd_vld_q, stat_rd_zero_q;
  logic [PRIO_BITS-1:0] prio_rd_q;
  logic                 prio_rd_vld_q, prio_rd_zero_q;
  logic [ID_W-1:0]      ring_rd_q;

  logic [ID_W-1:0]      tid_idx;
  logic                 tid_in_range;
  logic [PRIO_BITS-1:0] prio_req_m;
  slot_state_e          stat_eff;
  logic [PRIO_BITS-1:0] prio_eff;
  logic [15:0]          prio_wide;
  logic [SUM_W-1:0]     tail_sum;
  logic [ID_W-1:0]      tail, head_inc, head_dec;
  slot_state_e          blk_state;
  logic                 ring_full;

  logic                 stat_we;
  logic [ID_W-1:0]      stat_wa;
  slot_state_e          stat_wd;
  logic                 ring_we;
  logic [ID_W-1:0]      ring_wa, ring_wd;
  res_t                 res_d;

  assign tid_idx      = ID_W'(req_q.thread_id);
  assign tid_in_range = 32'(req_q.thread_id) < THREAD_SLOTS;
  assign prio_req_m   = PRIO_BITS'(req_q.priority_req);
  assign ring_full    = count_q == FULL_CNT;

  // Entries never written read as their reset contents.
  assign stat_eff = stat_rd_vld_q ? stat_rd_q :
                    (stat_rd_zero_q ? ST_RUNNING : ST_UNUSED);
  assign prio_eff = prio_rd_vld_q ? prio_rd_q :
                    (prio_rd_zero_q ? slot0_prio_q : '0);
  assign prio_wide = 16'(prio_eff);

  always_comb begin
    tail_sum = SUM_W'(head_q) + SUM_W'(count_q);
    if (tail_sum >= SLOTS_SUM) begin
      tail = ID_W'(tail_sum - SLOTS_SUM);
    end else begin
      tail = ID_W'(tail_sum);
    end
    head_inc = (head_q == LAST_SLOT) ? '0 : head_q + ID_W'(1);
    head_dec = (head_q == '0) ? LAST_SLOT : head_q - ID_W'(1);
    if (req_q.block_kind == KIND_WAITING) begin
      blk_state = ST_WAITING;
    end else if (req_q.block_kind == KIND_HANGING) begin
      blk_state = ST_HANGING;
    end else begin
      blk_state = ST_BLOCKED;
    end
  end

  always_comb begin
    stat_we = 1'b1;
    stat_wa = cur_q;
    stat_wd = ST_READY;
    if (cmd_i.wr_create || cmd_i.wr_front) begin
      stat_wa = tid_idx;
    end else if (cmd_i.wr_requeue) begin
      stat_wa = cur_q;
    end else if (cmd_i.wr_block) begin
      stat_wd = blk_state;
    end else if (cmd_i.pop) begin
      stat_wa = ring_rd_q;
      stat_wd = ST_RUNNING;
    end else begin
      stat_we = 1'b0;
    end

    ring_we = cmd_i.wr_create || cmd_i.wr_requeue || cmd_i.wr_front;
    ring_wa = cmd_i.wr_front ? head_dec : tail;
    ring_wd = cmd_i.wr_requeue ? cur_q : tid_idx;
  end

  // Slot state table.
  always_ff @(posedge clk_i) begin
    if (stat_we) begin
      stat_mem[stat_wa] <= stat_wd;
    end
    stat_rd_q      <= stat_mem[tid_idx];
    stat_rd_vld_q  <= stat_vld_q[tid_idx];
    stat_rd_zero_q <= tid_idx == '0;
  end

  // Slot priority table; only a create writes it.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_create) begin
      prio_mem[tid_idx] <= prio_req_m;
    end
    prio_rd_q      <= prio_mem[cur_q];
    prio_rd_vld_q  <= prio_vld_q[cur_q];
    prio_rd_zero_q <= cur_q == '0;
  end

  // Ready ring.
  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[ring_wa] <= ring_wd;
    end
    ring_rd_q <= ring_mem[head_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < THREAD_SLOTS; i++) begin
        stat_vld_q[i] <= 1'b0;
        prio_vld_q[i] <= 1'b0;
      end
    end else begin
      if (stat_we) begin
        stat_vld_q[stat_wa] <= 1'b1;
      end
      if (cmd_i.wr_create) begin
        prio_vld_q[tid_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q    <= 1'b0;
      slot0_prio_q <= PRIO_BITS'(MAIN_PRIO_RESET);
      head_q       <= '0;
      count_q      <= '0;
      cur_q        <= '0;
      idle_q       <= 1'b0;
      err_q        <= ERR_OK;
      switched_q   <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      // The register reaches slot zero only before the first request.
      if (cfg_valid_i && !started_q) begin
        slot0_prio_q <= PRIO_BITS'(cfg_data_i);
      end
      if (cmd_i.load) begin
        started_q  <= 1'b1;
        err_q      <= ERR_OK;
        switched_q <= 1'b0;
      end
      if (cmd_i.err_set) begin
        err_q <= cmd_i.err_val;
      end
      if (cmd_i.wr_create || cmd_i.wr_requeue || cmd_i.wr_front) begin
        count_q <= count_q + CNT_W'(1);
      end else if (cmd_i.pop) begin
        count_q <= count_q - CNT_W'(1);
      end
      if (cmd_i.wr_front) begin
        head_q <= head_dec;
      end else if (cmd_i.pop) begin
        head_q <= head_inc;
      end
      if (cmd_i.pop) begin
        cur_q      <= ring_rd_q;
        idle_q     <= 1'b0;
        switched_q <= 1'b1;
      end else if (cmd_i.go_idle) begin
        idle_q <= 1'b1;
      end
      res_valid_q <= cmd_i.emit;
    end
  end

  always_comb begin
    res_d.running_id = idle_q ? 4'd0 : 4'(cur_q);
    res_d.switched   = switched_q;
    res_d.time_slice = idle_q ? 8'd0 : prio_wide[7:0];
    res_d.error_code = err_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
    if (cmd_i.emit) begin
      res_q <= res_d;
    end
  end

  always_comb begin
    sts_o.op            = req_q.op;
    sts_o.cpu_idle      = idle_q;
    sts_o.ring_full     = ring_full;
    sts_o.ring_empty    = count_q == '0;
    sts_o.create_ok     = tid_in_range && (stat_eff == ST_UNUSED) && !ring_full;
    sts_o.unblock_bad   = !tid_in_range || (stat_eff == ST_RUNNING) ||
                          (stat_eff == ST_UNUSED);
    sts_o.unblock_ready = stat_eff == ST_READY;
  end

  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_CNT)
    else $error("ready ring count beyond slot count");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> count_q != '0)
    else $error("dispatch pop from an empty ring");

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.wr_create || cmd_i.wr_requeue || cmd_i.wr_front) |-> !ring_full)
    else $error("push into a full ring");

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |=> !res_valid_q)
    else $error("result strobe held for more than one cycle");
`endif

endmodule

>>> rtl/round_robin_thread_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_thread_scheduler: hardware round-robin thread scheduler
// Keeps slot states and priorities, a ready deque and the running thread,
// and serves create, time-slice expiry, block and unblock requests.
// ----------------------------------------------------------------------------
//
//  Channel  | Signals                              | Handshake
//  ---------+--------------------------------------+----------------------------
//  request  | start, busy, req_i                   | taken when start && !busy
//  result   | res_valid_o, res_o                   | one-cycle strobe, no stall
//  config   | cfg_valid_i, cfg_ready_o, cfg_data_i | written on valid && ready
//
// The result word and its strobe are registered at the edge that leaves S_EMIT.
// A create or unblock passes S_FETCH, S_APPLY, S_PRIO and S_EMIT; an expiry
// or block that dispatches adds S_DISPATCH and S_POP after S_APPLY, and skips
// S_POP when the ring turns out empty. The strobe is high for the cycle after
// that edge, and a new request is taken at the edge that ends it. The
// sequencer reads and writes the slot tables and the ring in separate
// steps. Reset is asynchronous and needs no clearing pass: slot tables carry
// per-entry valid bits. The receiver cannot stall results.
//
module round_robin_thread_scheduler #(
  parameter int unsigned THREAD_SLOTS = rrts_pkg::THREAD_SLOTS_DEF,
  parameter int unsigned PRIO_BITS    = rrts_pkg::PRIO_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  rrts_pkg::req_t req_i,
  output logic           res_valid_o,
  output rrts_pkg::res_t res_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [7:0]     cfg_data_i
);
  import rrts_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  // Configuration is only written while idle, so the port never pushes back.
  assign cfg_ready_o = 1'b1;

  // The controller walks each request through its phases; it sees the
  // datapath only through the status group and drives it only by commands.
  rrts_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // The datapath owns all scheduler state and the result register.
  rrts_datapath #(
    .THREAD_SLOTS (THREAD_SLOTS),
    .PRIO_BITS    (PRIO_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .res_o       (res_o),
    .res_valid_o (res_valid_o)
  );

endmodule

>>> tb/rrts_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_checker: scoreboard for the round-robin thread scheduler
// Watches the request, result and configuration channels, keeps its own copy
// of the slot tables and the ready deque, and compares each result word.
// ----------------------------------------------------------------------------
module rrts_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic           busy_i,
  input  rrts_pkg::req_t req_i,
  input  logic           res_valid_i,
  input  rrts_pkg::res_t res_i,
  input  logic           cfg_valid_i,
  input  logic           cfg_ready_i,
  input  logic [7:0]     cfg_data_i,
  output int             fail_count_o,
  output int             pending_o
);
  import rrts_pkg::*;

  localparam int SLOTS = THREAD_SLOTS_DEF;

  slot_state_e slot_state [SLOTS];
  logic [7:0]  slot_prio  [SLOTS];
  logic [3:0]  ready_ring [SLOTS];
  logic [3:0]  ring_head;
  int          ring_count;
  logic [3:0]  run_slot;
  logic        cpu_idle;
  logic        stepped;
  logic [7:0]  main_prio;
  res_t        sched_outcomes [$];

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: scheduler mismatch on %s: got %0d, expected %0d",
             $time, what, got, want);
    fail_count_o++;
  endtask

  function automatic void ring_append(input logic [3:0] id);
    ready_ring[ring_head + ring_count[3:0]] = id;
    ring_count++;
  endfunction

  // Moves the head of the deque onto the cpu; an empty deque idles it.
  function automatic err_e dispatch_head(output logic sw);
    logic [3:0] id;
    sw = 1'b0;
    if (ring_count == 0) begin
      cpu_idle = 1'b1;
      return ERR_NO_READY;
    end
    id = ready_ring[ring_head];
    ring_head++;
    ring_count--;
    slot_state[id] = ST_RUNNING;
    run_slot = id;
    cpu_idle = 1'b0;
    sw = 1'b1;
    return ERR_OK;
  endfunction

  function automatic res_t run_sched_op(input req_t r);
    res_t out;
    err_e err;
    logic sw;
    err = ERR_OK;
    sw = 1'b0;
    stepped = 1'b1;
    case (r.op)
      OP_CREATE: begin
        if (slot_state[r.thread_id] != ST_UNUSED || ring_count >= SLOTS) begin
          err = ERR_BUSY_FULL;
        end else begin
          slot_state[r.thread_id] = ST_READY;
          slot_prio[r.thread_id] = r.priority_req;
          ring_append(r.thread_id);
        end
      end
      OP_EXPIRE: begin
        if (!cpu_idle) begin
          if (ring_count >= SLOTS) begin
            err = ERR_BUSY_FULL;
          end else begin
            ring_append(run_slot);
            slot_state[run_slot] = ST_READY;
            err = dispatch_head(sw);
          end
        end else begin
          err = dispatch_head(sw);
        end
      end
      OP_BLOCK: begin
        if (!cpu_idle) begin
          case (r.block_kind)
            KIND_WAITING: slot_state[run_slot] = ST_WAITING;
            KIND_HANGING: slot_state[run_slot] = ST_HANGING;
            default:      slot_state[run_slot] = ST_BLOCKED;
          endcase
        end
        err = dispatch_head(sw);
      end
      default: begin
        if (slot_state[r.thread_id] == ST_RUNNING ||
            slot_state[r.thread_id] == ST_UNUSED) begin
          err = ERR_BAD_UNBLOCK;
        end else if (slot_state[r.thread_id] != ST_READY) begin
          if (ring_count >= SLOTS) begin
            err = ERR_BUSY_FULL;
          end else begin
            ring_head--;
            ready_ring[ring_head] = r.thread_id;
            ring_count++;
            slot_state[r.thread_id] = ST_READY;
          end
        end
      end
    endcase
    out.running_id = cpu_idle ? 4'd0 : run_slot;
    out.time_slice = cpu_idle ? 8'd0 : slot_prio[run_slot];
    out.switched   = sw;
    out.error_code = err;
    return out;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_state[i] = ST_UNUSED;
        slot_prio[i]  = 8'd0;
        ready_ring[i] = 4'd0;
      end
      main_prio     = MAIN_PRIO_RESET;
      slot_state[0] = ST_RUNNING;
      slot_prio[0]  = MAIN_PRIO_RESET;
      ring_head     = 4'd0;
      ring_count    = 0;
      run_slot      = 4'd0;
      cpu_idle      = 1'b0;
      stepped       = 1'b0;
      sched_outcomes.delete();
      fail_count_o  = 0;
      pending_o     = 0;
    end else begin
      // The main priority reaches slot zero only before the first step.
      if (cfg_valid_i && cfg_ready_i) begin
        main_prio = cfg_data_i;
        if (!stepped) slot_prio[0] = main_prio;
      end
      if (start_i && !busy_i) sched_outcomes.push_back(run_sched_op(req_i));
      if (res_valid_i) begin
        if (sched_outcomes.size() == 0) begin
          report_mismatch("unrequested result word", res_i.running_id, -1);
        end else begin
          want = sched_outcomes.pop_front();
          if (res_i.running_id != want.running_id)
            report_mismatch("running_id", res_i.running_id, want.running_id);
          if (res_i.switched != want.switched)
            report_mismatch("switched", res_i.switched, want.switched);
          if (res_i.time_slice != want.time_slice)
            report_mismatch("time_slice", res_i.time_slice, want.time_slice);
          if (res_i.error_code != want.error_code)
            report_mismatch("error_code", int'(res_i.error_code), int'(want.error_code));
        end
      end
      pending_o = sched_outcomes.size();
    end
  end

endmodule

>>> tb/round_robin_thread_scheduler_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_thread_scheduler_tb: top of the scheduler testbench
// Drives directed and random scheduling requests with random gaps, writes
// the main priority register between phases, and reports the verdict that
// follows from the checker's failure count and a no-progress watchdog.
// ----------------------------------------------------------------------------
module round_robin_thread_scheduler_tb;
  import rrts_pkg::*;

  // Cycles without any handshake before the run is declared hung.
  localparam int STALL_LIMIT = 2000;

  logic       clk_i;
  logic       rst_ni;
  logic       start;
  logic       busy;
  req_t       req_word;
  logic       res_valid;
  res_t       res_word;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [7:0] cfg_data;

  int         fail_count;
  int         pending;
  int         quiet_cycles;
  // When set, requests are sent back to back with no gaps.
  logic       steady;

  round_robin_thread_scheduler DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_word),
    .res_valid_o (res_valid),
    .res_o       (res_word),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  rrts_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .req_i        (req_word),
    .res_valid_i  (res_valid),
    .res_i        (res_word),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // The watchdog restarts on every accepted request word, result word or
  // register write, so it only fires when the block stops making progress.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || res_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("** round_robin_thread_scheduler: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Sends one request word. Called at a falling edge; returns at the falling
  // edge after the word was taken, with start still high so that a request
  // with no gap follows without start dropping.
  task automatic issue(input op_e op, input logic [3:0] tid, input logic [7:0] prio,
                       input logic [1:0] kind);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start    <= 1'b1;
    req_word <= '{op: op, thread_id: tid, priority_req: prio, block_kind: kind};
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  // Drops start and holds the sender back until every result word is in.
  // Each request yields exactly one result, so the block is idle afterwards.
  task automatic drain;
    start <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic write_main_prio(input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // Random requests. Expiry, block and unblock dominate so that threads keep
  // moving between the cpu, the deque and the blocked states; creates fill
  // the unused slots early and afterwards probe the busy-slot error.
  task automatic run_random(input int count, input logic mid_drain);
    int pick;
    op_e op;
    for (int k = 0; k < count; k++) begin
      if (k % 64 == 0) steady = ($urandom_range(0, 3) == 0);
      if (mid_drain && k == count / 2) drain();
      pick = $urandom_range(0, 99);
      if (pick < 12)      op = OP_CREATE;
      else if (pick < 47) op = OP_EXPIRE;
      else if (pick < 70) op = OP_BLOCK;
      else                op = OP_UNBLOCK;
      issue(op, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
            2'($urandom_range(0, 3)));
    end
  endtask

  initial begin
    rst_ni    = 1'b0;
    start     = 1'b0;
    req_word  = '0;
    cfg_valid = 1'b0;
    cfg_data  = 8'd0;
    steady    = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Both extremes of the main priority before the first step; the last
    // one sticks to slot zero, so its slice shows up in the results.
    write_main_prio(8'd0);
    write_main_prio(8'd255);

    // Directed part. The cpu starts on slot zero with an empty deque.
    issue(OP_EXPIRE,  4'd0,  8'd0,   2'd0);          // re-queue and pick itself
    issue(OP_CREATE,  4'd0,  8'h80,  2'd0);          // slot already in use
    issue(OP_UNBLOCK, 4'd0,  8'd0,   2'd0);          // unblock of the runner
    issue(OP_UNBLOCK, 4'd5,  8'd0,   2'd0);          // unblock of an unused slot
    issue(OP_BLOCK,   4'd0,  8'd0,   KIND_WAITING);  // deque empty: cpu idles
    issue(OP_EXPIRE,  4'd0,  8'd0,   2'd0);          // idle, still nothing ready
    issue(OP_BLOCK,   4'd0,  8'd0,   2'd3);          // block while idle
    issue(OP_CREATE,  4'd15, 8'd255, 2'd0);
    issue(OP_CREATE,  4'd1,  8'd0,   2'd0);
    issue(OP_UNBLOCK, 4'd15, 8'd0,   2'd0);          // already ready: no change
    issue(OP_EXPIRE,  4'd0,  8'd0,   2'd0);          // idle cpu takes the head
    issue(OP_BLOCK,   4'd0,  8'd0,   KIND_HANGING);
    issue(OP_BLOCK,   4'd0,  8'd0,   2'd3);          // unknown kind means blocked
    issue(OP_UNBLOCK, 4'd15, 8'd0,   2'd0);          // pushes to the front
    issue(OP_UNBLOCK, 4'd1,  8'd0,   2'd0);
    issue(OP_UNBLOCK, 4'd0,  8'd0,   2'd0);          // a waiting thread returns
    issue(OP_EXPIRE,  4'd0,  8'd0,   2'd0);
    issue(OP_EXPIRE,  4'd0,  8'd0,   2'd0);
    issue(OP_BLOCK,   4'd0,  8'd0,   2'd0);
    issue(OP_CREATE,  4'd10, 8'hAA,  2'd0);
    issue(OP_UNBLOCK, 4'd1,  8'd0,   2'd0);
    issue(OP_EXPIRE,  4'd0,  8'd0,   2'd0);
    drain();

    // After the first step the register no longer touches slot zero, but
    // it is still written across its range between phases.
    write_main_prio(8'd0);
    run_random(380, 1'b0);
    drain();
    write_main_prio(8'($urandom_range(1, 254)));
    run_random(380, 1'b1);
    drain();
    write_main_prio(8'd255);
    run_random(390, 1'b0);
    drain();

    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("** round_robin_thread_scheduler: PASSED **");
    end else begin
      $display("** round_robin_thread_scheduler: FAILED **");
    end
    $finish;
  end

endmodule
